// ----- design/pfs_pkg.sv -----
`timescale 1ns / 1ps

package pfs_pkg;

   typedef enum logic [1:0] {
      OP_LOAD_OBSTACLE = 2'd0,
      OP_STEP          = 2'd1,
      OP_SET_POSITION  = 2'd2,
      OP_UNUSED        = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_OBSTACLE_COUNT = 3'd0,
      CSR_RANGE_LIMIT    = 3'd1,
      CSR_GOAL_GAIN      = 3'd2,
      CSR_OBSTACLE_GAIN  = 3'd3,
      CSR_STEP_LENGTH    = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RANGE,
      ST_RCAP,
      ST_FETCH,
      ST_DX,
      ST_GOAL,
      ST_DY,
      ST_D2,
      ST_CHECK,
      ST_TMUL,
      ST_TDIV0,
      ST_TDIV,
      ST_TACC,
      ST_ZERO,
      ST_NORM,
      ST_SQX,
      ST_SQY,
      ST_SQS,
      ST_SQRT,
      ST_LEN,
      ST_MMUL,
      ST_MDIV0,
      ST_MDIV,
      ST_MACC,
      ST_MOVE,
      ST_ARR,
      ST_ARR2,
      ST_ARR3,
      ST_ARR4,
      ST_DONE
   } state_type;

   localparam logic [6:0]  RST_OBSTACLE_COUNT = 7'd0;
   localparam logic [9:0]  RST_RANGE_LIMIT    = 10'd200;
   localparam logic [15:0] RST_GOAL_GAIN      = 16'd1000;
   localparam logic [15:0] RST_OBSTACLE_GAIN  = 16'd200;
   localparam logic [7:0]  RST_STEP_LENGTH    = 8'd30;
   localparam int          RST_POSITION       = 20;

   localparam logic [5:0] DIV_LAST  = 6'd39;
   localparam logic [5:0] SQRT_LAST = 6'd31;

   localparam logic signed [39:0] SUM_MAX = {1'b0, {39{1'b1}}};
   localparam logic signed [39:0] SUM_MIN = {1'b1, {39{1'b0}}};

endpackage

// ----- design/potential_field_step.sv -----
`timescale 1ns / 1ps
// Potential-field path step.
// A request is taken when start is high and busy is low. Operation 0 loads an
// obstacle into a table slot, operation 2 sets the robot position, operation 1
// steps the robot toward the goal given in the request, and operation 3 only
// reports the position. Every request gives exactly one response: rsp_valid is
// high for one cycle with the robot position and the arrived and no_force flags.
// Load, set and unused requests respond in the cycle right after acceptance, so
// a new request can be taken once that response has been given.
// A step request runs a sequencer around one shared 32x32 multiplier, one
// restoring divider that retires one quotient bit per cycle, and a square root
// unit that retires one root bit per cycle. Each obstacle in range takes two
// divisions, one out of range none, the goal term two more, and the final
// normalization, root and two move divisions follow. Busy stays high for the
// whole request, so one request is worked on at a time.
// The receiver cannot stall; the response is shown for one cycle only.
// Synchronous reset returns the robot to (20,20) clamped to the map and the
// registers to their defaults; obstacle table contents are unknown until loaded.
// Configuration writes are taken at any edge outside reset with csr_write_enable high.
module potential_field_step #(
   parameter int MAP_WIDTH     = 512,
   parameter int MAP_HEIGHT    = 512,
   parameter int MAX_OBSTACLES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [8:0]  req_point_x,
   input  logic [8:0]  req_point_y,
   input  logic [5:0]  req_obstacle_slot,
   output logic        rsp_valid,
   output logic [8:0]  rsp_position_x,
   output logic [8:0]  rsp_position_y,
   output logic        rsp_arrived,
   output logic        rsp_no_force,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int TOP_X = ((MAP_WIDTH < 512) ? MAP_WIDTH : 512) - 1;
   localparam int TOP_Y = ((MAP_HEIGHT < 512) ? MAP_HEIGHT : 512) - 1;
   localparam logic [8:0] RST_X = 9'((pfs_pkg::RST_POSITION > TOP_X) ? TOP_X
                                                                      : pfs_pkg::RST_POSITION);
   localparam logic [8:0] RST_Y = 9'((pfs_pkg::RST_POSITION > TOP_Y) ? TOP_Y
                                                                      : pfs_pkg::RST_POSITION);
   localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CNT_B = $clog2(MAX_OBSTACLES + 1);
   localparam int CW    = (CNT_B > 7) ? CNT_B : 7;

   pfs_pkg::state_type state_ff, state_in;

   logic [6:0]  count_ff;
   logic [9:0]  range_ff;
   logic [15:0] goal_gain_ff;
   logic [15:0] obst_gain_ff;
   logic [7:0]  step_ff;

   logic [8:0]  robot_x_ff, robot_y_ff;
   logic [8:0]  px_ff, py_ff;
   logic        arrived_ff, no_force_ff;

   logic [17:0] table_mem [MAX_OBSTACLES];
   logic [17:0] rd_ff;

   logic [CW-1:0] idx_ff, limit_ff;
   logic          goal_ff, axis_ff;
   logic signed [9:0] dx_ff, dy_ff;
   logic [19:0]   d2_ff, r2_ff;

   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_p_ff;

   logic [39:0]   quo_ff;
   logic [31:0]   rem_ff, den_ff;
   logic [5:0]    cnt_ff;

   logic signed [39:0] fx_ff, fy_ff;
   logic [39:0]   ax_ff, ay_ff;
   logic [63:0]   sq_ff, sv_ff, sr_ff, sbit_ff;
   logic [31:0]   len_ff;
   logic [7:0]    mx_ff, my_ff;

   logic signed [9:0] dx_new, dy_new;
   logic [9:0]    dx_abs, dy_abs, d_abs;
   logic          d_neg;
   logic [32:0]   div_trial;
   logic          div_ge;
   logic [63:0]   sq_trial;
   logic signed [41:0] acc_sum, acc_old, acc_add;
   logic signed [39:0] acc_sat;
   logic signed [10:0] new_x, new_y;
   logic [8:0]    clamp_x, clamp_y;

   always_comb begin
      case (state_ff)
         pfs_pkg::ST_GOAL: begin
            dx_new = $signed({1'b0, px_ff}) - $signed({1'b0, robot_x_ff});
            dy_new = $signed({1'b0, py_ff}) - $signed({1'b0, robot_y_ff});
         end
         pfs_pkg::ST_ARR: begin
            dx_new = $signed({1'b0, px_ff}) - $signed({1'b0, robot_x_ff});
            dy_new = $signed({1'b0, py_ff}) - $signed({1'b0, robot_y_ff});
         end
         default: begin
            dx_new = $signed({1'b0, rd_ff[17:9]}) - $signed({1'b0, robot_x_ff});
            dy_new = $signed({1'b0, rd_ff[8:0]}) - $signed({1'b0, robot_y_ff});
         end
      endcase
      dx_abs    = dx_new[9] ? 10'(-dx_new) : 10'(dx_new);
      dy_abs    = dy_ff[9] ? 10'(-dy_ff) : 10'(dy_ff);
      d_neg     = axis_ff ? dy_ff[9] : dx_ff[9];
      d_abs     = axis_ff ? dy_abs : (dx_ff[9] ? 10'(-dx_ff) : 10'(dx_ff));
      div_trial = {rem_ff, quo_ff[39]};
      div_ge    = div_trial >= {1'b0, den_ff};
      sq_trial  = sr_ff + sbit_ff;
      acc_old   = axis_ff ? 42'(fy_ff) : 42'(fx_ff);
      acc_add   = (d_neg ^ !goal_ff) ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
      acc_sum   = acc_old + acc_add;
      if (acc_sum[41:39] == 3'b000 || acc_sum[41:39] == 3'b111) begin
         acc_sat = acc_sum[39:0];
      end else if (acc_sum[41]) begin
         acc_sat = pfs_pkg::SUM_MIN;
      end else begin
         acc_sat = pfs_pkg::SUM_MAX;
      end
      new_x = $signed({2'b00, robot_x_ff}) + (fx_ff[39] ? -$signed({3'b000, mx_ff})
                                                         : $signed({3'b000, mx_ff}));
      new_y = $signed({2'b00, robot_y_ff}) + (fy_ff[39] ? -$signed({3'b000, my_ff})
                                                         : $signed({3'b000, my_ff}));
      if (new_x < 0) begin
         clamp_x = 9'd0;
      end else if (new_x > $signed(11'(TOP_X))) begin
         clamp_x = 9'(TOP_X);
      end else begin
         clamp_x = new_x[8:0];
      end
      if (new_y < 0) begin
         clamp_y = 9'd0;
      end else if (new_y > $signed(11'(TOP_Y))) begin
         clamp_y = 9'(TOP_Y);
      end else begin
         clamp_y = new_y[8:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfs_pkg::ST_IDLE: begin
            if (start) begin
               if (req_operation == pfs_pkg::OP_STEP) begin
                  state_in = pfs_pkg::ST_RANGE;
               end else begin
                  state_in = pfs_pkg::ST_DONE;
               end
            end
         end
         pfs_pkg::ST_RANGE: state_in = pfs_pkg::ST_RCAP;
         pfs_pkg::ST_RCAP:  state_in = pfs_pkg::ST_FETCH;
         pfs_pkg::ST_FETCH: begin
            if (idx_ff >= limit_ff) begin
               state_in = pfs_pkg::ST_GOAL;
            end else begin
               state_in = pfs_pkg::ST_DX;
            end
         end
         pfs_pkg::ST_DX:    state_in = pfs_pkg::ST_DY;
         pfs_pkg::ST_GOAL:  state_in = pfs_pkg::ST_DY;
         pfs_pkg::ST_DY:    state_in = pfs_pkg::ST_D2;
         pfs_pkg::ST_D2:    state_in = pfs_pkg::ST_CHECK;
         pfs_pkg::ST_CHECK: begin
            if (goal_ff) begin
               state_in = (d2_ff == 20'd0) ? pfs_pkg::ST_ZERO : pfs_pkg::ST_TMUL;
            end else if (d2_ff == 20'd0 || d2_ff >= r2_ff) begin
               state_in = pfs_pkg::ST_FETCH;
            end else begin
               state_in = pfs_pkg::ST_TMUL;
            end
         end
         pfs_pkg::ST_TMUL:  state_in = pfs_pkg::ST_TDIV0;
         pfs_pkg::ST_TDIV0: state_in = pfs_pkg::ST_TDIV;
         pfs_pkg::ST_TDIV: begin
            if (cnt_ff == pfs_pkg::DIV_LAST) begin
               state_in = pfs_pkg::ST_TACC;
            end
         end
         pfs_pkg::ST_TACC: begin
            if (!axis_ff) begin
               state_in = pfs_pkg::ST_TMUL;
            end else if (goal_ff) begin
               state_in = pfs_pkg::ST_ZERO;
            end else begin
               state_in = pfs_pkg::ST_FETCH;
            end
         end
         pfs_pkg::ST_ZERO: begin
            if (fx_ff == 40'sd0 && fy_ff == 40'sd0) begin
               state_in = pfs_pkg::ST_ARR;
            end else begin
               state_in = pfs_pkg::ST_NORM;
            end
         end
         pfs_pkg::ST_NORM: begin
            if (ax_ff[39:31] == 9'd0 && ay_ff[39:31] == 9'd0) begin
               state_in = pfs_pkg::ST_SQX;
            end
         end
         pfs_pkg::ST_SQX:   state_in = pfs_pkg::ST_SQY;
         pfs_pkg::ST_SQY:   state_in = pfs_pkg::ST_SQS;
         pfs_pkg::ST_SQS:   state_in = pfs_pkg::ST_SQRT;
         pfs_pkg::ST_SQRT: begin
            if (cnt_ff == pfs_pkg::SQRT_LAST) begin
               state_in = pfs_pkg::ST_LEN;
            end
         end
         pfs_pkg::ST_LEN:   state_in = pfs_pkg::ST_MMUL;
         pfs_pkg::ST_MMUL:  state_in = pfs_pkg::ST_MDIV0;
         pfs_pkg::ST_MDIV0: state_in = pfs_pkg::ST_MDIV;
         pfs_pkg::ST_MDIV: begin
            if (cnt_ff == pfs_pkg::DIV_LAST) begin
               state_in = pfs_pkg::ST_MACC;
            end
         end
         pfs_pkg::ST_MACC: state_in = axis_ff ? pfs_pkg::ST_MOVE : pfs_pkg::ST_MMUL;
         pfs_pkg::ST_MOVE: state_in = pfs_pkg::ST_ARR;
         pfs_pkg::ST_ARR:  state_in = pfs_pkg::ST_ARR2;
         pfs_pkg::ST_ARR2: state_in = pfs_pkg::ST_ARR3;
         pfs_pkg::ST_ARR3: state_in = pfs_pkg::ST_ARR4;
         pfs_pkg::ST_ARR4: state_in = pfs_pkg::ST_DONE;
         pfs_pkg::ST_DONE: state_in = pfs_pkg::ST_IDLE;
         default:          state_in = pfs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy           = (state_ff != pfs_pkg::ST_IDLE);
      rsp_valid      = (state_ff == pfs_pkg::ST_DONE);
      rsp_position_x = robot_x_ff;
      rsp_position_y = robot_y_ff;
      rsp_arrived    = arrived_ff;
      rsp_no_force   = no_force_ff;
      mul_a          = 32'd0;
      mul_b          = 32'd0;
      case (state_ff)
         pfs_pkg::ST_RANGE: begin
            mul_a = 32'(range_ff);
            mul_b = 32'(range_ff);
         end
         pfs_pkg::ST_DX, pfs_pkg::ST_GOAL, pfs_pkg::ST_ARR: begin
            mul_a = 32'(dx_abs);
            mul_b = 32'(dx_abs);
         end
         pfs_pkg::ST_DY, pfs_pkg::ST_ARR2: begin
            mul_a = 32'(dy_abs);
            mul_b = 32'(dy_abs);
         end
         pfs_pkg::ST_TMUL: begin
            mul_a = 32'(goal_ff ? goal_gain_ff : obst_gain_ff);
            mul_b = 32'(d_abs);
         end
         pfs_pkg::ST_SQX: begin
            mul_a = ax_ff[31:0];
            mul_b = ax_ff[31:0];
         end
         pfs_pkg::ST_SQY: begin
            mul_a = ay_ff[31:0];
            mul_b = ay_ff[31:0];
         end
         pfs_pkg::ST_MMUL: begin
            mul_a = axis_ff ? ay_ff[31:0] : ax_ff[31:0];
            mul_b = 32'(step_ff);
         end
         pfs_pkg::ST_ARR3: begin
            mul_a = 32'(step_ff);
            mul_b = 32'(step_ff);
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfs_pkg::ST_IDLE;
         count_ff     <= pfs_pkg::RST_OBSTACLE_COUNT;
         range_ff     <= pfs_pkg::RST_RANGE_LIMIT;
         goal_gain_ff <= pfs_pkg::RST_GOAL_GAIN;
         obst_gain_ff <= pfs_pkg::RST_OBSTACLE_GAIN;
         step_ff      <= pfs_pkg::RST_STEP_LENGTH;
         robot_x_ff   <= RST_X;
         robot_y_ff   <= RST_Y;
         arrived_ff   <= 1'b0;
         no_force_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               pfs_pkg::CSR_OBSTACLE_COUNT: count_ff     <= csr_write_data[6:0];
               pfs_pkg::CSR_RANGE_LIMIT:    range_ff     <= csr_write_data[9:0];
               pfs_pkg::CSR_GOAL_GAIN:      goal_gain_ff <= csr_write_data;
               pfs_pkg::CSR_OBSTACLE_GAIN:  obst_gain_ff <= csr_write_data;
               pfs_pkg::CSR_STEP_LENGTH:    step_ff      <= csr_write_data[7:0];
               default: begin
               end
            endcase
         end
         if (state_ff == pfs_pkg::ST_IDLE && start) begin
            arrived_ff  <= 1'b0;
            no_force_ff <= 1'b0;
            if (req_operation == pfs_pkg::OP_SET_POSITION) begin
               robot_x_ff <= (32'(req_point_x) > TOP_X) ? 9'(TOP_X) : req_point_x;
               robot_y_ff <= (32'(req_point_y) > TOP_Y) ? 9'(TOP_Y) : req_point_y;
            end
         end
         if (state_ff == pfs_pkg::ST_ZERO && fx_ff == 40'sd0 && fy_ff == 40'sd0) begin
            no_force_ff <= 1'b1;
         end
         if (state_ff == pfs_pkg::ST_MOVE) begin
            robot_x_ff <= clamp_x;
            robot_y_ff <= clamp_y;
         end
         if (state_ff == pfs_pkg::ST_ARR4) begin
            arrived_ff <= (44'(d2_ff) <= 44'(mul_p_ff[15:0]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pfs_pkg::ST_IDLE && start &&
          req_operation == pfs_pkg::OP_LOAD_OBSTACLE &&
          32'(req_obstacle_slot) < MAX_OBSTACLES) begin
         table_mem[IDX_W'(req_obstacle_slot)] <= {req_point_x, req_point_y};
      end
      if (state_ff == pfs_pkg::ST_FETCH) begin
         rd_ff <= table_mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= 64'(mul_a) * 64'(mul_b);
      case (state_ff)
         pfs_pkg::ST_IDLE: begin
            px_ff <= req_point_x;
            py_ff <= req_point_y;
         end
         pfs_pkg::ST_RANGE: begin
            idx_ff   <= '0;
            goal_ff  <= 1'b0;
            axis_ff  <= 1'b0;
            fx_ff    <= 40'sd0;
            fy_ff    <= 40'sd0;
            limit_ff <= (CW'(count_ff) > CW'(MAX_OBSTACLES)) ? CW'(MAX_OBSTACLES)
                                                            : CW'(count_ff);
         end
         pfs_pkg::ST_RCAP: r2_ff <= mul_p_ff[19:0];
         pfs_pkg::ST_DX: begin
            dx_ff  <= dx_new;
            dy_ff  <= dy_new;
            idx_ff <= idx_ff + CW'(1);
         end
         pfs_pkg::ST_GOAL: begin
            dx_ff   <= dx_new;
            dy_ff   <= dy_new;
            goal_ff <= 1'b1;
         end
         pfs_pkg::ST_DY: d2_ff <= mul_p_ff[19:0];
         pfs_pkg::ST_D2: d2_ff <= d2_ff + mul_p_ff[19:0];
         pfs_pkg::ST_TDIV0, pfs_pkg::ST_MDIV0: begin
            quo_ff <= (state_ff == pfs_pkg::ST_TDIV0) ? {mul_p_ff[25:0], 14'd0}
                                                      : mul_p_ff[39:0];
            den_ff <= (state_ff == pfs_pkg::ST_TDIV0) ? 32'(d2_ff) : len_ff;
            rem_ff <= 32'd0;
            cnt_ff <= 6'd0;
         end
         pfs_pkg::ST_TDIV, pfs_pkg::ST_MDIV: begin
            rem_ff <= div_ge ? 32'(div_trial - {1'b0, den_ff}) : div_trial[31:0];
            quo_ff <= {quo_ff[38:0], div_ge};
            cnt_ff <= cnt_ff + 6'd1;
         end
         pfs_pkg::ST_TACC: begin
            if (axis_ff) begin
               fy_ff <= acc_sat;
            end else begin
               fx_ff <= acc_sat;
            end
            axis_ff <= !axis_ff;
         end
         pfs_pkg::ST_ZERO: begin
            ax_ff <= fx_ff[39] ? 40'(-fx_ff) : 40'(fx_ff);
            ay_ff <= fy_ff[39] ? 40'(-fy_ff) : 40'(fy_ff);
         end
         pfs_pkg::ST_NORM: begin
            if (ax_ff[39:31] != 9'd0 || ay_ff[39:31] != 9'd0) begin
               ax_ff <= ax_ff >> 1;
               ay_ff <= ay_ff >> 1;
            end
         end
         pfs_pkg::ST_SQY: sq_ff <= mul_p_ff;
         pfs_pkg::ST_SQS: begin
            sv_ff   <= sq_ff + mul_p_ff;
            sr_ff   <= 64'd0;
            sbit_ff <= 64'd1 << 62;
            cnt_ff  <= 6'd0;
         end
         pfs_pkg::ST_SQRT: begin
            if (sv_ff >= sq_trial) begin
               sv_ff <= sv_ff - sq_trial;
               sr_ff <= (sr_ff >> 1) + sbit_ff;
            end else begin
               sr_ff <= sr_ff >> 1;
            end
            sbit_ff <= sbit_ff >> 2;
            cnt_ff  <= cnt_ff + 6'd1;
         end
         pfs_pkg::ST_LEN: begin
            len_ff  <= (sr_ff == 64'd0) ? 32'd1 : sr_ff[31:0];
            axis_ff <= 1'b0;
         end
         pfs_pkg::ST_MACC: begin
            if (axis_ff) begin
               my_ff <= quo_ff[7:0];
            end else begin
               mx_ff <= quo_ff[7:0];
            end
            axis_ff <= !axis_ff;
         end
         pfs_pkg::ST_ARR: begin
            dx_ff <= dx_new;
            dy_ff <= dy_new;
         end
         pfs_pkg::ST_ARR2: d2_ff <= mul_p_ff[19:0];
         pfs_pkg::ST_ARR3: d2_ff <= d2_ff + mul_p_ff[19:0];
         default: begin
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   a_idle_after_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after its response");

   a_divider_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfs_pkg::ST_TDIV || state_ff == pfs_pkg::ST_MDIV)
         |-> cnt_ff <= pfs_pkg::DIV_LAST)
      else $error("divider ran past its last quotient bit");
`endif

endmodule
